// ----- rtl/sliding_median_filter_assert.svh -----
// ----------------------------------------------------------------------------
// Sliding median filter assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_ASSERT_SVH

`ifndef SYNTH

// checked only outside reset
`define SMF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SMF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/smf_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding median filter package
// Shared constants and the sorter command type.
// ----------------------------------------------------------------------------
package smf_pkg;

	localparam int MAX_WINDOW_DEF   = 63;
	localparam int SAMPLE_WIDTH_DEF = 20;

	localparam int           CFG_W    = 6;
	localparam logic [5:0]   WS_RESET = 6'd31;

	// commands from the sequencer to the sorter chain
	typedef struct packed {
		logic clear;
		logic insert;
		logic shift;
	} sort_cmd_t;

endpackage

// ----- rtl/sliding_median_filter.sv -----
// ----------------------------------------------------------------------------
// Sliding median filter
// Centered running median over a sample stream, truncated windows at the ends.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries sample and last; output channel
// out_valid/out_ready carries median_doubled (twice the median) and last_res.
// cfg_we/cfg_wdata write window_size; do so only while the block is idle.
// Each sample is stored in a circular history RAM. Per result, the newest cnt
// samples are read one per cycle into a chain of sorting cells, then the chain
// shifts (cnt-1)/2 times so the middle value(s) sit in cells 0 and 1.
// Here cnt is the window count, at most 2*half+1. A last sample flushes up to
// half+1 results in a row. in_ready is high only between items, so a new
// sample is not taken before every result of the previous one is computed.
// A finished result sits in the output register; the next one is computed
// meanwhile and waits in the sorter cells if the receiver stalls.
// Reset clears the sample count and sets window_size to 31; history RAM
// contents are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
`include "sliding_median_filter_assert.svh"

module sliding_median_filter #(
	parameter int MAX_WINDOW   = smf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = smf_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [smf_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_WIDTH:0]  median_doubled,
	output logic                          last_res
);

	localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
	localparam int ADDR_W   = $clog2(MAX_WINDOW);
	localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;
	localparam int CW       = (CNT_W > smf_pkg::CFG_W) ? CNT_W : smf_pkg::CFG_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_SHIFT = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]                state_q;
	logic [smf_pkg::CFG_W-1:0] ws_q;
	logic [CNT_W-1:0]          seen_q;
	logic [ADDR_W-1:0]         wp_q;
	logic [CNT_W-1:0]          t_q;
	logic [CNT_W-1:0]          h_q;
	logic [CNT_W-1:0]          d_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          sh_q;
	logic [ADDR_W-1:0]         k_q;
	logic                      last_q;
	logic                      ins_s1;

	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH:0]   med_q;
	logic                           last_res_q;

	logic                           in_xfer;
	logic                           out_free;
	logic                           ld_out;
	logic [CW-1:0]                  h_raw;
	logic [CNT_W-1:0]               half_c;
	logic [CNT_W-1:0]               first_d;
	logic                           has_res;
	logic [CNT_W-1:0]               span_sum;
	logic [CNT_W-1:0]               span_c;
	logic [CNT_W-1:0]               cnt_c;
	logic [CNT_W-1:0]               sh_c;
	logic [ADDR_W:0]                rd_tmp;
	logic [ADDR_W-1:0]              rd_addr;
	logic [ADDR_W-1:0]              wp_next;
	logic signed [SAMPLE_WIDTH-1:0] rd_data;
	logic signed [SAMPLE_WIDTH-1:0] low0;
	logic signed [SAMPLE_WIDTH-1:0] low1;
	logic signed [SAMPLE_WIDTH-1:0] mid_b;
	logic signed [SAMPLE_WIDTH:0]   med_c;
	smf_pkg::sort_cmd_t             sort_cmd;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign ld_out   = (state_q == ST_OUT) && out_free;

	// half-width, clamped to what the history can hold
	assign h_raw   = CW'(ws_q >> 1);
	assign half_c  = (h_raw > CW'(HALF_MAX)) ? CNT_W'(HALF_MAX) : CNT_W'(h_raw);
	assign first_d = (last && (seen_q < half_c)) ? seen_q : half_c;
	assign has_res = last || (seen_q >= half_c);

	// window of the current position: d samples after it, truncated at the start
	assign span_sum = d_q + h_q;
	assign span_c   = (span_sum > t_q) ? t_q : span_sum;
	assign cnt_c    = span_c + 1'b1;
	assign sh_c     = (cnt_q - 1'b1) >> 1;

	// newest-first read address: wp - 1 - k, modulo depth
	assign rd_tmp  = {1'b0, wp_q} + (ADDR_W+1)'(MAX_WINDOW - 1) - {1'b0, k_q};
	assign rd_addr = (rd_tmp >= (ADDR_W+1)'(MAX_WINDOW)) ?
		ADDR_W'(rd_tmp - (ADDR_W+1)'(MAX_WINDOW)) : ADDR_W'(rd_tmp);
	assign wp_next = (wp_q == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;

	// odd count doubles the middle, even count adds the two middles
	assign mid_b = cnt_q[0] ? low0 : low1;
	assign med_c = {low0[SAMPLE_WIDTH-1], low0} + {mid_b[SAMPLE_WIDTH-1], mid_b};

	assign sort_cmd.clear  = (state_q == ST_SETUP);
	assign sort_cmd.insert = ins_s1;
	assign sort_cmd.shift  = (state_q == ST_SHIFT);

	smf_hist #(
		.DEPTH (MAX_WINDOW),
		.SW    (SAMPLE_WIDTH),
		.ADDR_W(ADDR_W)
	) u_hist (
		.clk  (clk),
		.we   (in_xfer),
		.waddr(wp_q),
		.wdata(sample),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	smf_sorter #(
		.N (MAX_WINDOW),
		.SW(SAMPLE_WIDTH)
	) u_sorter (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (sort_cmd),
		.x     (rd_data),
		.low0  (low0),
		.low1  (low1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= smf_pkg::WS_RESET;
		end else if (cfg_we) begin
			ws_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= '0;
			wp_q        <= '0;
			ins_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// read data is registered and arrives in the cycle after its address
			ins_s1      <= (state_q == ST_LOAD);
			out_valid_q <= ld_out || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						wp_q <= wp_next;
						if (last) begin
							seen_q <= '0;
						end else if (seen_q != CNT_W'(MAX_WINDOW)) begin
							seen_q <= seen_q + 1'b1;
						end
						if (has_res) begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (k_q == ADDR_W'(cnt_q - 1'b1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= (sh_c == '0) ? ST_OUT : ST_SHIFT;
				end
				ST_SHIFT: begin
					if (sh_q == CNT_W'(1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= (last_q && (d_q != '0)) ? ST_SETUP : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// job bookkeeping and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					t_q    <= seen_q;
					h_q    <= half_c;
					d_q    <= first_d;
					last_q <= last;
				end
			end
			ST_SETUP: begin
				cnt_q <= cnt_c;
				k_q   <= '0;
			end
			ST_LOAD: begin
				k_q <= k_q + 1'b1;
			end
			ST_DRAIN: begin
				sh_q <= sh_c;
			end
			ST_SHIFT: begin
				sh_q <= sh_q - 1'b1;
			end
			ST_OUT: begin
				if (out_free) begin
					med_q      <= med_c;
					last_res_q <= last_q && (d_q == '0);
					if (d_q != '0) begin
						d_q <= d_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign median_doubled = med_q;
	assign last_res       = last_res_q;

	`SMF_ASSERT(a_out_from_seq, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_OUT), "result loaded outside output state")
	`SMF_ASSERT(a_read_in_window, clk, arst_n, (state_q == ST_LOAD) |-> (k_q < cnt_q), "history read beyond window")
	`SMF_ASSERT(a_last_clears, clk, arst_n, (in_xfer && last) |=> (seen_q == '0), "sample count not cleared after last")
	`SMF_ASSERT(a_seen_sat, clk, arst_n, seen_q <= CNT_W'(MAX_WINDOW), "sample count past saturation")

endmodule

// ----- rtl/smf_hist.sv -----
// ----------------------------------------------------------------------------
// Sample history memory
// Circular buffer of recent samples, one write and one registered read port.
// ----------------------------------------------------------------------------
module smf_hist #(
	parameter int DEPTH  = smf_pkg::MAX_WINDOW_DEF,
	parameter int SW     = smf_pkg::SAMPLE_WIDTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic        [ADDR_W-1:0] waddr,
	input  logic signed [SW-1:0]     wdata,
	input  logic        [ADDR_W-1:0] raddr,
	output logic signed [SW-1:0]     rdata
);

	logic signed [SW-1:0] mem [DEPTH];
	logic signed [SW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/smf_cell.sv -----
// ----------------------------------------------------------------------------
// Sorter cell
// One slot of the ascending insertion chain; empty slots act as +infinity.
// ----------------------------------------------------------------------------
module smf_cell #(
	parameter int SW = smf_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smf_pkg::sort_cmd_t   cmd,
	input  logic signed [SW-1:0] x,
	input  logic signed [SW-1:0] lo_val,
	input  logic                 lo_vld,
	input  logic                 lo_gt,
	input  logic signed [SW-1:0] hi_val,
	input  logic                 hi_vld,
	output logic signed [SW-1:0] val,
	output logic                 vld,
	output logic                 gt
);

	logic signed [SW-1:0] val_q;
	logic                 vld_q;

	// new value belongs at or below this slot
	assign gt = !vld_q || (x < val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.clear) begin
			vld_q <= 1'b0;
		end else if (cmd.insert && gt) begin
			vld_q <= lo_gt ? lo_vld : 1'b1;
		end else if (cmd.shift) begin
			vld_q <= hi_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && gt) begin
			val_q <= lo_gt ? lo_val : x;
		end else if (cmd.shift) begin
			val_q <= hi_val;
		end
	end

	assign val = val_q;
	assign vld = vld_q;

endmodule

// ----- rtl/smf_sorter.sv -----
// ----------------------------------------------------------------------------
// Sorter chain
// Row of insertion cells; shifts toward cell 0 to walk the sorted order.
// ----------------------------------------------------------------------------
module smf_sorter #(
	parameter int N  = smf_pkg::MAX_WINDOW_DEF,
	parameter int SW = smf_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smf_pkg::sort_cmd_t   cmd,
	input  logic signed [SW-1:0] x,
	output logic signed [SW-1:0] low0,
	output logic signed [SW-1:0] low1
);

	logic signed [SW-1:0] val_w [N];
	logic                 vld_w [N];
	logic                 gt_w  [N];

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			logic signed [SW-1:0] lo_val;
			logic                 lo_vld;
			logic                 lo_gt;
			logic signed [SW-1:0] hi_val;
			logic                 hi_vld;

			if (i == 0) begin : g_bot
				assign lo_val = '0;
				assign lo_vld = 1'b0;
				assign lo_gt  = 1'b0;
			end else begin : g_mid_lo
				assign lo_val = val_w[i-1];
				assign lo_vld = vld_w[i-1];
				assign lo_gt  = gt_w[i-1];
			end

			if (i == N - 1) begin : g_top
				assign hi_val = '0;
				assign hi_vld = 1'b0;
			end else begin : g_mid_hi
				assign hi_val = val_w[i+1];
				assign hi_vld = vld_w[i+1];
			end

			smf_cell #(
				.SW(SW)
			) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.cmd   (cmd),
				.x     (x),
				.lo_val(lo_val),
				.lo_vld(lo_vld),
				.lo_gt (lo_gt),
				.hi_val(hi_val),
				.hi_vld(hi_vld),
				.val   (val_w[i]),
				.vld   (vld_w[i]),
				.gt    (gt_w[i])
			);
		end
	endgenerate

	assign low0 = val_w[0];
	assign low1 = val_w[1];

endmodule

// ----- tb/sv/sliding_median_filter_tb.sv -----
// ----------------------------------------------------------------------------
// Sliding median filter testbench
// Streams sample sequences through the filter under several window settings.
// A directed table comes first, then random sequences of random length. Each
// sample transfer runs a behavioral median model that queues the expected
// results. Each result transfer is compared against the oldest queued entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sliding_median_filter_tb;

	localparam int MAXW        = smf_pkg::MAX_WINDOW_DEF;
	localparam int SW          = smf_pkg::SAMPLE_WIDTH_DEF;
	localparam int HALF_CAP    = (MAXW - 1) / 2;
	localparam int ITEM_TARGET = 470;
	localparam int CALM_TAIL   = 60;
	localparam int SETTLE      = 128;
	localparam int WD_LIMIT    = 2000;

	localparam logic signed [SW-1:0] SMP_MIN = 20'sh80000;
	localparam logic signed [SW-1:0] SMP_MAX = 20'sh7FFFF;
	localparam logic signed [SW:0]   MD_MIN  = 21'sh100000;
	localparam logic signed [SW:0]   MD_MAX  = 21'sh0FFFFE;

	typedef struct packed {
		logic signed [SW:0] md;
		logic               lr;
	} median_res_t;

	// typed rows carry their single expected result, the rest use the model
	typedef struct packed {
		logic                    cfg;
		logic [smf_pkg::CFG_W-1:0] ws;
		logic signed [SW-1:0]    smp;
		logic                    lst;
		logic                    typed;
		logic signed [SW:0]      md;
		logic                    lr;
	} dir_row_t;

	localparam int DIR_N = 18;
	localparam dir_row_t DIR_TAB [0:DIR_N-1] = '{
		// reset window: single-sample sequences at the extremes and at zero
		'{1'b0, 6'd0,  SMP_MIN,   1'b1, 1'b1, MD_MIN,  1'b1},
		'{1'b0, 6'd0,  SMP_MAX,   1'b1, 1'b1, MD_MAX,  1'b1},
		'{1'b0, 6'd0,  20'sd0,    1'b1, 1'b1, 21'sd0,  1'b1},
		// window zero: one sample per window
		'{1'b1, 6'd0,  20'sd100,  1'b0, 1'b1, 21'sd200, 1'b0},
		'{1'b0, 6'd0,  -20'sd7,   1'b1, 1'b1, -21'sd14, 1'b1},
		'{1'b1, 6'd3,  20'sd5,    1'b0, 1'b0, 21'sd0,  1'b0},
		'{1'b0, 6'd0,  -20'sd3,   1'b0, 1'b0, 21'sd0,  1'b0},
		'{1'b0, 6'd0,  SMP_MAX,   1'b0, 1'b0, 21'sd0,  1'b0},
		'{1'b0, 6'd0,  SMP_MIN,   1'b0, 1'b0, 21'sd0,  1'b0},
		'{1'b0, 6'd0,  20'sd10,   1'b1, 1'b0, 21'sd0,  1'b0},
		// even size acts as the next odd one
		'{1'b1, 6'd2,  20'sd1,    1'b0, 1'b0, 21'sd0,  1'b0},
		'{1'b0, 6'd0,  20'sd2,    1'b0, 1'b0, 21'sd0,  1'b0},
		'{1'b0, 6'd0,  20'sd3,    1'b1, 1'b0, 21'sd0,  1'b0},
		// widest window, sequence shorter than the window
		'{1'b1, 6'd63, SMP_MIN,   1'b0, 1'b0, 21'sd0,  1'b0},
		'{1'b0, 6'd0,  SMP_MAX,   1'b0, 1'b0, 21'sd0,  1'b0},
		'{1'b0, 6'd0,  SMP_MAX,   1'b0, 1'b0, 21'sd0,  1'b0},
		'{1'b0, 6'd0,  SMP_MIN,   1'b1, 1'b0, 21'sd0,  1'b0},
		'{1'b1, 6'd1,  20'sd42,   1'b1, 1'b1, 21'sd84, 1'b1}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [smf_pkg::CFG_W-1:0]   cfg_wdata;
	logic                        in_valid;
	logic                        in_ready;
	logic signed [SW-1:0]        sample;
	logic                        last;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic signed [SW:0]          median_doubled;
	logic                        last_res;

	// model state
	logic signed [SW-1:0]        hist [0:MAXW-1];
	int                          seen_cnt;
	logic [smf_pkg::CFG_W-1:0]   win_cur;

	median_res_t                 median_q [$];
	median_res_t                 step_res [$];

	int  fails;
	int  items_sent;
	int  seqs_sent;
	int  medians_checked;
	int  cfg_writes;
	int  idle_cycles;
	int  ready_hold;
	bit  calm;
	bit  gappy;

	sliding_median_filter uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.median_doubled (median_doubled),
		.last_res       (last_res)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// twice the median of the newest cnt history entries
	function automatic logic signed [SW:0] mid_twice(input int cnt);
		logic signed [SW-1:0] ord [0:MAXW-1];
		logic signed [SW-1:0] v;
		logic signed [SW:0]   a;
		logic signed [SW:0]   b;
		int i;
		int j;
		for (i = 0; i < cnt; i++) begin
			v = hist[i];
			j = i;
			while (j > 0 && ord[j-1] > v) begin
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = v;
		end
		if (cnt % 2) begin
			a = ord[cnt/2];
			return a + a;
		end
		a = ord[cnt/2 - 1];
		b = ord[cnt/2];
		return a + b;
	endfunction

	// advance the model by one sample; results land in step_res
	task automatic predict_median(input logic signed [SW-1:0] s, input logic l);
		int half;
		int t;
		int d;
		int span;
		int k;
		median_res_t r;
		half = win_cur / 2;
		if (half > HALF_CAP)
			half = HALF_CAP;
		t = seen_cnt;
		for (k = MAXW - 1; k > 0; k--)
			hist[k] = hist[k-1];
		hist[0] = s;
		if (!l) begin
			if (t >= half) begin
				span = 2 * half;
				if (span > t)
					span = t;
				r = '{mid_twice(span + 1), 1'b0};
				step_res.insert(step_res.size(), r);
			end
			if (seen_cnt < MAXW)
				seen_cnt++;
		end else begin
			// flush: oldest pending position first, windows cut at the end
			for (d = (t < half) ? t : half; d >= 0; d--) begin
				span = d + half;
				if (span > t)
					span = t;
				r = '{mid_twice(span + 1), (d == 0)};
				step_res.insert(step_res.size(), r);
			end
			seen_cnt = 0;
		end
	endtask

	task automatic send_sample(input logic signed [SW-1:0] s, input logic l,
			input logic typed, input logic signed [SW:0] md, input logic lr);
		median_res_t r;
		in_valid <= 1'b1;
		sample   <= s;
		last     <= l;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (l)
			seqs_sent++;
		if (items_sent >= ITEM_TARGET - CALM_TAIL)
			calm = 1'b1;
		predict_median(s, l);
		if (typed) begin
			step_res.delete();
			r = '{md, lr};
			median_q.insert(median_q.size(), r);
		end else begin
			while (step_res.size() != 0)
				median_q.insert(median_q.size(), step_res.pop_front());
		end
		if (!calm && gappy && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// only between sequences, with every expected median already out
	task automatic set_window(input logic [smf_pkg::CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (median_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		win_cur  = v;
		cfg_writes++;
	endtask

	function automatic logic signed [SW-1:0] rand_sample();
		int v;
		case ($urandom_range(0, 5))
			0: return SW'($urandom);
			1: return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
			2, 3: begin
				// narrow range forces ties in the window
				v = int'($urandom_range(0, 16)) - 8;
				return v[SW-1:0];
			end
			default: begin
				v = int'($urandom_range(0, 8192)) - 4096;
				return v[SW-1:0];
			end
		endcase
	endfunction

	// receiver: ready in random bursts, held high at the tail of the run
	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (ready_hold == 0) begin
			if ($urandom_range(0, 2) != 0) begin
				out_ready  <= 1'b1;
				ready_hold  = $urandom_range(1, 40);
			end else begin
				out_ready  <= 1'b0;
				ready_hold  = $urandom_range(1, 15);
			end
		end else begin
			ready_hold--;
		end
	end

	always @(posedge clk) begin
		median_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (median_q.size() == 0) begin
				$error("unexpected result transfer: median_doubled %0d, last_res %0b",
					median_doubled, last_res);
				fails++;
			end else begin
				e = median_q.pop_front();
				medians_checked++;
				if (median_doubled !== e.md) begin
					$error("median_doubled: expected %0d, actual %0d", e.md, median_doubled);
					fails++;
				end
				if (last_res !== e.lr) begin
					$error("last_res: expected %0b, actual %0b", e.lr, last_res);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d medians pending",
				WD_LIMIT, median_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int i;
		int nseq;
		int len;
		int half;
		int j;
		logic [smf_pkg::CFG_W-1:0] ws;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		in_valid        = 1'b0;
		sample          = '0;
		last            = 1'b0;
		fails           = 0;
		items_sent      = 0;
		seqs_sent       = 0;
		medians_checked = 0;
		cfg_writes      = 0;
		idle_cycles     = 0;
		ready_hold      = 0;
		calm            = 1'b0;
		gappy           = 1'b1;
		seen_cnt        = 0;
		win_cur         = smf_pkg::WS_RESET;
		for (i = 0; i < MAXW; i++)
			hist[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_N; i++) begin
			if (DIR_TAB[i].cfg)
				set_window(DIR_TAB[i].ws);
			send_sample(DIR_TAB[i].smp, DIR_TAB[i].lst, DIR_TAB[i].typed,
				DIR_TAB[i].md, DIR_TAB[i].lr);
		end

		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 5))
				0: ws = 6'd0;
				1: ws = 6'd63;
				2: ws = 6'($urandom_range(1, 2));
				default: ws = 6'($urandom_range(0, 63));
			endcase
			set_window(ws);
			half = (ws / 2 > HALF_CAP) ? HALF_CAP : ws / 2;
			nseq = $urandom_range(1, 4);
			while (nseq > 0 && items_sent < ITEM_TARGET) begin
				case ($urandom_range(0, 9))
					0, 1: len = $urandom_range(1, 3);
					2: len = $urandom_range(60, 90);   // can saturate the sample count
					default: len = $urandom_range(1, 2 * half + 6);
				endcase
				// the final sequence is cut short to land on the item count
				if (len > ITEM_TARGET - items_sent)
					len = ITEM_TARGET - items_sent;
				gappy = $urandom_range(0, 2) != 0;
				for (j = 0; j < len; j++)
					send_sample(rand_sample(), j == len - 1, 1'b0, '0, 1'b0);
				nseq--;
			end
		end

		in_valid <= 1'b0;
		while (median_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d samples in %0d sequences sent, %0d medians checked",
			items_sent, seqs_sent, medians_checked);
		$display("%0d window size writes, sizes 0, 1, 2, 63 and random between",
			cfg_writes);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
